// ===== sv/bsf_pkg.sv =====
package bsf_pkg;

    localparam int unsigned DATA_W         = 8;
    localparam int unsigned PADDR_W        = 3;
    localparam int unsigned PDATA_W        = 32;
    localparam int unsigned LIMIT_W        = DATA_W + 1;
    localparam int unsigned ONES_W         = 3;
    localparam int unsigned IDX_W          = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [DATA_W-1:0]  FLAG_PATTERN   = 8'h7E;
    localparam logic [ONES_W-1:0]  STUFF_LIMIT    = 3'd5;
    localparam logic [DATA_W-1:0]  FRAME_LEN_RST  = 8'd4;
    localparam logic [LIMIT_W-1:0] FRAME_LEN_MAX  = 9'd256;
    localparam logic [IDX_W-1:0]   IDX_MSB        = 3'd7;
    localparam logic [IDX_W-1:0]   IDX_LSB        = 3'd0;

    localparam logic REG_FRAME_LEN = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              open_flag;
        logic              close_flag;
    } t_item;

    typedef enum logic [1:0] {
        PH_OPEN,
        PH_DATA,
        PH_STUFF,
        PH_CLOSE
    } t_phase;

endpackage

// ===== sv/bsf_front.sv =====
module bsf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [bsf_pkg::DATA_W-1:0] i_data_byte,
    input  logic                       i_end_of_message,
    input  logic                       i_full,
    input  logic [bsf_pkg::DATA_W-1:0] i_frame_len,
    output logic                       o_push,
    output bsf_pkg::t_item             o_item
);
    import bsf_pkg::*;

    logic [DATA_W-1:0]  r_bytes_in_frame;
    logic [DATA_W-1:0]  n_bytes_in_frame;
    logic [LIMIT_W-1:0] w_limit;
    logic [LIMIT_W-1:0] w_count;
    logic               w_close;

    always_comb begin
        w_limit = (i_frame_len == '0) ? FRAME_LEN_MAX : {1'b0, i_frame_len};
        w_count = {1'b0, r_bytes_in_frame} + LIMIT_W'(1);
        w_close = (w_count >= w_limit) || i_end_of_message;
        o_push  = i_in_valid && !i_full;

        o_item.data       = i_data_byte;
        o_item.open_flag  = (r_bytes_in_frame == '0);
        o_item.close_flag = w_close;

        n_bytes_in_frame = r_bytes_in_frame;
        if (o_push) begin
            n_bytes_in_frame = w_close ? '0 : w_count[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_in_frame <= '0;
        end else begin
            r_bytes_in_frame <= n_bytes_in_frame;
        end
    end

endmodule

// ===== sv/bsf_queue.sv =====
module bsf_queue #(
    parameter int unsigned DEPTH = bsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bsf_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output bsf_pkg::t_item o_item
);
    import bsf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    always_comb begin
        o_full  = (r_count == CNT_FULL);
        o_valid = (r_count != '0);
        o_item  = r_mem[r_rd_ptr];
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

endmodule

// ===== sv/bsf_back.sv =====
module bsf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  bsf_pkg::t_item i_q_item,
    output logic           o_pop,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic           o_line_bit,
    output logic           o_is_flag_bit,
    output logic           o_last_of_run
);
    import bsf_pkg::*;

    t_phase             r_phase;
    t_phase             n_phase;
    logic               r_active;
    logic               n_active;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [ONES_W-1:0]  r_ones;
    logic [ONES_W-1:0]  n_ones;
    logic               r_out_valid;
    logic               r_line_bit;
    logic               r_is_flag_bit;
    logic               r_last_of_run;

    t_phase             w_phase;
    logic [IDX_W-1:0]   w_idx;
    logic [ONES_W-1:0]  w_ones_inc;
    logic               w_advance;
    logic               w_emit;
    logic               w_bit;
    logic               w_flag;
    logic               w_last;
    logic               w_done;

    always_comb begin
        w_advance = !r_out_valid || !i_out_stall;
        w_emit    = w_advance && i_q_valid;

        if (r_active) begin
            w_phase = r_phase;
            w_idx   = r_idx;
        end else begin
            w_phase = i_q_item.open_flag ? PH_OPEN : PH_DATA;
            w_idx   = IDX_MSB;
        end

        n_phase    = w_phase;
        n_idx      = w_idx;
        n_ones     = r_ones;
        w_bit      = 1'b0;
        w_flag     = 1'b0;
        w_done     = 1'b0;
        w_ones_inc = r_ones + ONES_W'(1);

        case (w_phase)
            PH_OPEN: begin
                w_bit  = FLAG_PATTERN[w_idx];
                w_flag = 1'b1;
                n_ones = '0;
                if (w_idx == IDX_LSB) begin
                    n_phase = PH_DATA;
                    n_idx   = IDX_MSB;
                end else begin
                    n_idx = w_idx - IDX_W'(1);
                end
            end
            PH_DATA: begin
                w_bit  = i_q_item.data[w_idx];
                n_ones = w_bit ? w_ones_inc : '0;
                if (w_bit && (w_ones_inc == STUFF_LIMIT)) begin
                    n_phase = PH_STUFF;
                    n_ones  = '0;
                end else if (w_idx != IDX_LSB) begin
                    n_idx = w_idx - IDX_W'(1);
                end else if (i_q_item.close_flag) begin
                    n_phase = PH_CLOSE;
                    n_idx   = IDX_MSB;
                end else begin
                    w_done = 1'b1;
                end
            end
            PH_STUFF: begin
                if (w_idx != IDX_LSB) begin
                    n_phase = PH_DATA;
                    n_idx   = w_idx - IDX_W'(1);
                end else if (i_q_item.close_flag) begin
                    n_phase = PH_CLOSE;
                    n_idx   = IDX_MSB;
                end else begin
                    w_done = 1'b1;
                end
            end
            PH_CLOSE: begin
                w_bit  = FLAG_PATTERN[w_idx];
                w_flag = 1'b1;
                if (w_idx == IDX_LSB) begin
                    w_done = 1'b1;
                end else begin
                    n_idx = w_idx - IDX_W'(1);
                end
            end
            default: begin
                w_done = 1'b1;
            end
        endcase

        w_last   = w_done;
        n_active = !w_done;
        o_pop    = w_emit && w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_phase     <= PH_OPEN;
            r_idx       <= IDX_MSB;
            r_ones      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_active <= n_active;
                r_phase  <= n_phase;
                r_idx    <= n_idx;
                r_ones   <= n_ones;
            end
            if (w_advance) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_line_bit    <= w_bit;
            r_is_flag_bit <= w_flag;
            r_last_of_run <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_bit    = r_line_bit;
    assign o_is_flag_bit = r_is_flag_bit;
    assign o_last_of_run = r_last_of_run;

endmodule

// ===== sv/bit_stuffing_flag_framer.sv =====
// Serial framer with flag delimiting and zero insertion. Payload bytes enter
// one per transfer and leave as one line bit per output transfer, framed by
// 01111110 at each frame start and end, with a 0 inserted after five payload
// ones. Register 0 (byte address 0) sets the bytes per frame; 0 means 256.
// A byte leaves as its 8 data bits, any inserted 0s and a flag pattern for
// each flag it carries; the bit serialiser sends one bit per cycle unless
// stalled; the input side accepts bytes until the small item queue in front of it is full.
module bit_stuffing_flag_framer #(
    parameter int unsigned QUEUE_DEPTH = bsf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bsf_pkg::PADDR_W-1:0] paddr,
    input  logic [bsf_pkg::PDATA_W-1:0] pwdata,
    output logic [bsf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [bsf_pkg::DATA_W-1:0]  i_data_byte,
    input  logic                        i_end_of_message,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_line_bit,
    output logic                        o_is_flag_bit,
    output logic                        o_last_of_run
);
    import bsf_pkg::*;

    logic [DATA_W-1:0] r_frame_len;
    logic              w_full;
    logic              w_push;
    logic              w_pop;
    logic              w_q_valid;
    t_item             w_push_item;
    t_item             w_q_item;

    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_FRAME_LEN) begin
            prdata = {{(PDATA_W-DATA_W){1'b0}}, r_frame_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RST;
        end else if (psel && penable && pwrite && pready
                     && (paddr[PADDR_W-1] == REG_FRAME_LEN)) begin
            r_frame_len <= pwdata[DATA_W-1:0];
        end
    end

    assign o_in_stall = w_full;

    bsf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_full           (w_full),
        .i_frame_len      (r_frame_len),
        .o_push           (w_push),
        .o_item           (w_push_item)
    );

    bsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    bsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_pop         (w_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_line_bit    (o_line_bit),
        .o_is_flag_bit (o_is_flag_bit),
        .o_last_of_run (o_last_of_run)
    );

endmodule
